FILE: src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the HSV to RGB converter.
// Used by hsv2rgb_level and hsv_to_rgb_converter_top; depends on nothing else.

package hsv2rgb_pkg;

    // Field widths of the item channels.
    localparam int HUE_W = 13;
    localparam int CH_W  = 8;

    // Default number of fraction bits in the hue field.
    localparam int HUE_FRAC_BITS_DEF = 4;

    // Sector split: hue >> (frac + 2) is divided by 15, since 60 = 4 * 15.
    localparam int SEC_Y_W    = 11;
    localparam int SEC_DIV    = 15;
    localparam int SEC_RECIP  = 4369;   // floor(2^16 / 15)
    localparam int SEC_SHIFT  = 16;
    localparam int SEC_PROD_W = 24;

    // Level scaling: the numerator, shifted down by the fraction bits, is
    // divided by 255 * 60 = 15300 through a reciprocal and one correction.
    localparam int LVL_T_W     = 22;
    localparam int LVL_DIV     = 15300;
    localparam int LVL_RECIP   = 4491469;   // floor(2^36 / 15300)
    localparam int LVL_RECIP_W = 23;
    localparam int LVL_SHIFT   = 36;

    // Input item: hue, saturation and brightness.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_hsv_in;

    // Result item: the three color channels.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_out;

    // Stage enables of the level unit.
    typedef struct packed {
        logic diff;
        logic num;
        logic quot;
        logic fix;
    } t_lvl_en;

    // The six 60-degree hue sectors.
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    // Per-item information that travels beside the level unit.
    typedef struct packed {
        t_sector         sector;
        logic            gray;
        logic            black;
        logic [CH_W-1:0] val;
    } t_side;

endpackage

FILE: src/hsv2rgb_level.sv
`timescale 1ns / 1ps
// Four-stage unit that computes floor(v * (1 - s/255 * part/D)) on a 0..255 scale.
// Depends on hsv2rgb_pkg for widths, the divisor constants and the enable struct.

module hsv2rgb_level #(
    parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  hsv2rgb_pkg::t_lvl_en              i_en,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      i_sat,
    input  logic [hsv2rgb_pkg::CH_W-1:0]      i_val,
    input  logic [HUE_FRAC_BITS+5:0]          i_part,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_level
);
    import hsv2rgb_pkg::*;

    localparam int DEN_W  = HUE_FRAC_BITS + 14;
    localparam int NUM_W  = DEN_W + CH_W;
    localparam int PROD_W = LVL_T_W + LVL_RECIP_W;
    localparam logic [DEN_W-1:0] DEN = DEN_W'(LVL_DIV) << HUE_FRAC_BITS;

    logic [DEN_W-1:0]   w_sp;
    logic [NUM_W-1:0]   w_num;
    logic [PROD_W-1:0]  w_prod;
    logic [LVL_T_W-1:0] w_rem;

    logic [DEN_W-1:0]   r_diff;
    logic [CH_W-1:0]    r_val;
    logic [LVL_T_W-1:0] r_t;
    logic [LVL_T_W-1:0] r_t_q;
    logic [CH_W-1:0]    r_qe;
    logic [CH_W-1:0]    r_level;

    // First stage: full scale minus saturation times the sector position.
    assign w_sp = DEN_W'(i_sat) * DEN_W'(i_part);

    // Second stage: scale by brightness and drop the hue fraction bits.
    assign w_num = NUM_W'(r_diff) * NUM_W'(r_val);

    // Third stage: quotient estimate by 15300, low by at most one.
    assign w_prod = PROD_W'(r_t) * PROD_W'(LVL_RECIP);

    // Fourth stage: remainder check lifts the estimate when it fell short.
    assign w_rem = r_t_q - LVL_T_W'(r_qe) * LVL_T_W'(LVL_DIV);

    always_ff @(posedge i_clk) begin
        if (i_en.diff) begin
            r_diff <= DEN - w_sp;
            r_val  <= i_val;
        end
        if (i_en.num) begin
            r_t <= w_num[HUE_FRAC_BITS +: LVL_T_W];
        end
        if (i_en.quot) begin
            r_qe  <= w_prod[LVL_SHIFT +: CH_W];
            r_t_q <= r_t;
        end
        if (i_en.fix) begin
            r_level <= r_qe + CH_W'(w_rem >= LVL_T_W'(LVL_DIV));
        end
    end

    assign o_level = r_level;

endmodule

FILE: src/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter: sector split, three level units, color select.
// Depends on hsv2rgb_pkg and hsv2rgb_level.

// Usage:
// An item on the input channel carries hue (degrees, fixed point with
// HUE_FRAC_BITS fraction bits), saturation and brightness; the result item
// carries 8-bit red, green and blue. Both channels use valid and stall: an
// item moves at a clock edge where valid is high and stall is low.
// The datapath is a seven-stage pipeline: sector estimate, sector correction,
// four stages of level scaling (multiply, multiply, reciprocal multiply,
// remainder correction) and the channel select register. One item is taken
// every cycle while the receiver does not stall. The rate is set by the stage
// registers alone; each stage passes its item on when the stage after it frees
// up. When the receiver raises i_stall, the output holds its item and earlier
// stages keep filling their empty slots; o_stall rises only once the first
// stage is occupied and cannot move. Nothing is dropped or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline and holds o_stall
// high; no clearing pass follows and items are accepted in the next cycle.

module hsv_to_rgb_converter_top #(
    parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  hsv2rgb_pkg::t_hsv_in  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output hsv2rgb_pkg::t_rgb_out o_data
);
    import hsv2rgb_pkg::*;

    localparam int SECT_UNITS = 60 << HUE_FRAC_BITS;
    localparam int PART_W     = HUE_FRAC_BITS + 6;
    localparam int LOW_W      = HUE_FRAC_BITS + 2;
    localparam int NSTG       = 7;
    localparam logic [CH_W-1:0] SECTORS = CH_W'(6);
    localparam logic [PART_W-1:0] PART_FULL = PART_W'(SECT_UNITS);

    // Handshake and stage occupancy.
    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] w_en;
    t_lvl_en         w_lvl_en;

    // Stage 0 registers and their inputs.
    logic [SEC_Y_W-1:0]    w_y;
    logic [SEC_PROD_W-1:0] w_sec_prod;
    logic [SEC_Y_W-1:0]    r0_y;
    logic [CH_W-1:0]       r0_q;
    logic [LOW_W-1:0]      r0_low;
    logic [CH_W-1:0]       r0_sat;
    logic [CH_W-1:0]       r0_val;

    // Stage 1 logic and registers.
    logic [SEC_Y_W-1:0] w_rem;
    logic               w_fix;
    logic [CH_W-1:0]    w_q;
    logic [3:0]         w_rem4;
    logic [PART_W-1:0]  w_part_b;
    logic               w_wrap;
    t_side              w_side;
    t_side              r1_side;
    logic [PART_W-1:0]  r1_part_b;
    logic [PART_W-1:0]  r1_part_c;
    logic [CH_W-1:0]    r1_sat;

    // Side information beside the level units, stages 2 to 5.
    t_side r_side_d [2:5];

    // Level unit results.
    logic [CH_W-1:0] w_lvl_a;
    logic [CH_W-1:0] w_lvl_b;
    logic [CH_W-1:0] w_lvl_c;

    // Output stage.
    t_rgb_out n_out;
    t_rgb_out r_out;
    logic     r_out_gray;
    logic     r_out_black;

    // A stage loads when it is empty or when the stage after it moves.
    always_comb begin
        w_en[NSTG-1] = !r_valid[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    // No item is taken while reset is asserted.
    assign o_stall = !w_en[0] || !i_rst_n;
    assign o_valid = r_valid[NSTG-1];

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage 0: estimate hue / (60 << frac) as (hue >> (frac + 2)) / 15.
    assign w_y        = SEC_Y_W'(i_data.hue >> LOW_W);
    assign w_sec_prod = SEC_PROD_W'(w_y) * SEC_PROD_W'(SEC_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_y   <= w_y;
            r0_q   <= w_sec_prod[SEC_SHIFT +: CH_W];
            r0_low <= i_data.hue[LOW_W-1:0];
            r0_sat <= i_data.saturation;
            r0_val <= i_data.brightness;
        end
    end

    // Stage 1: correct the sector, rebuild the position inside the sector,
    // and flag the gray, wrap and black cases.
    assign w_rem    = r0_y - SEC_Y_W'(r0_q) * SEC_Y_W'(SEC_DIV);
    assign w_fix    = (w_rem >= SEC_Y_W'(SEC_DIV));
    assign w_q      = r0_q + CH_W'(w_fix);
    assign w_rem4   = w_fix ? 4'(w_rem - SEC_Y_W'(SEC_DIV)) : w_rem[3:0];
    assign w_part_b = {w_rem4, r0_low};
    // A hue of exactly one full turn lands at sector six, position zero.
    assign w_wrap   = (w_q == SECTORS) && (w_part_b == '0);

    always_comb begin
        w_side.gray  = (r0_sat == '0);
        w_side.black = !w_wrap && (w_q >= SECTORS);
        w_side.val   = r0_val;
        if (w_wrap || w_q >= SECTORS) begin
            w_side.sector = SEC_R_TO_Y;
        end else begin
            w_side.sector = t_sector'(w_q[2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_side   <= w_side;
            r1_part_b <= w_wrap ? '0 : w_part_b;
            r1_part_c <= PART_FULL - (w_wrap ? '0 : w_part_b);
            r1_sat    <= r0_sat;
        end
    end

    // Stages 2 to 5: the three levels, computed side by side.
    assign w_lvl_en.diff = w_en[2];
    assign w_lvl_en.num  = w_en[3];
    assign w_lvl_en.quot = w_en[4];
    assign w_lvl_en.fix  = w_en[5];

    hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_level_a (
        .i_clk   (i_clk),
        .i_en    (w_lvl_en),
        .i_sat   (r1_sat),
        .i_val   (r1_side.val),
        .i_part  (PART_FULL),
        .o_level (w_lvl_a)
    );

    hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_level_b (
        .i_clk   (i_clk),
        .i_en    (w_lvl_en),
        .i_sat   (r1_sat),
        .i_val   (r1_side.val),
        .i_part  (r1_part_b),
        .o_level (w_lvl_b)
    );

    hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_level_c (
        .i_clk   (i_clk),
        .i_en    (w_lvl_en),
        .i_sat   (r1_sat),
        .i_val   (r1_side.val),
        .i_part  (r1_part_c),
        .o_level (w_lvl_c)
    );

    // Side information keeps pace with the level units.
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_side_d[2] <= r1_side;
        end
        for (int k = 3; k <= 5; k++) begin
            if (w_en[k]) begin
                r_side_d[k] <= r_side_d[k-1];
            end
        end
    end

    // Stage 6: route the levels to the channels by sector.
    always_comb begin
        n_out.red   = '0;
        n_out.green = '0;
        n_out.blue  = '0;
        case (r_side_d[5].sector)
            SEC_R_TO_Y: begin
                n_out.red   = r_side_d[5].val;
                n_out.green = w_lvl_c;
                n_out.blue  = w_lvl_a;
            end
            SEC_Y_TO_G: begin
                n_out.red   = w_lvl_b;
                n_out.green = r_side_d[5].val;
                n_out.blue  = w_lvl_a;
            end
            SEC_G_TO_C: begin
                n_out.red   = w_lvl_a;
                n_out.green = r_side_d[5].val;
                n_out.blue  = w_lvl_c;
            end
            SEC_C_TO_B: begin
                n_out.red   = w_lvl_a;
                n_out.green = w_lvl_b;
                n_out.blue  = r_side_d[5].val;
            end
            SEC_B_TO_M: begin
                n_out.red   = w_lvl_c;
                n_out.green = w_lvl_a;
                n_out.blue  = r_side_d[5].val;
            end
            SEC_M_TO_R: begin
                n_out.red   = r_side_d[5].val;
                n_out.green = w_lvl_a;
                n_out.blue  = w_lvl_b;
            end
            default: begin
                n_out.red   = '0;
                n_out.green = '0;
                n_out.blue  = '0;
            end
        endcase
        // Zero saturation wins over every hue case.
        if (r_side_d[5].gray) begin
            n_out.red   = r_side_d[5].val;
            n_out.green = r_side_d[5].val;
            n_out.blue  = r_side_d[5].val;
        end else if (r_side_d[5].black) begin
            n_out.red   = '0;
            n_out.green = '0;
            n_out.blue  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_out       <= n_out;
            r_out_gray  <= r_side_d[5].gray;
            r_out_black <= r_side_d[5].black && !r_side_d[5].gray;
        end
    end

    assign o_data = r_out;

    // A gray item leaves with all three channels equal.
    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_out_gray |->
            (o_data.red == o_data.green) && (o_data.green == o_data.blue))
        else $error("gray item with unequal channels");

    // A hue past one full turn gives black.
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_out_black |->
            (o_data.red == '0) && (o_data.green == '0) && (o_data.blue == '0))
        else $error("out-of-range hue did not give black");

    // With the receiver never stalling, an accepted item reaches the output once it has passed every stage register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
            ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("item did not reach the output in seven cycles");

endmodule
